[rtl/core/tsos_pkg.sv]
// Package for the transpose self-organizing search block.
// Holds field widths, input mode codes, controller states and the
// command/status structs shared by the controller and the datapath.
`default_nettype none

package tsos_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int DATA_W        = 32;
  localparam int IDX_W         = 6;
  localparam int COUNT_W       = 7;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SWAP_LO,
    S_SWAP_HI,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;       // capture key and search limit
    logic load_entry;  // write the load transaction into the table
    logic scan;        // issue one read and compare one entry
    logic swap_lo;     // write key into the entry before the match
    logic swap_hi;     // write the previous entry into the match slot
    logic post;        // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
    logic hit_above_zero;
    logic miss;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

[rtl/core/tsos_if.sv]
// Channel interfaces of the transpose self-organizing search block.
// Input item, result item and configuration write channels; uses tsos_pkg.
`default_nettype none

interface tsos_item_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic [tsos_pkg::IDX_W-1:0]        entry_index;
  logic signed [tsos_pkg::DATA_W-1:0] item_value;

  modport source (output valid, mode, entry_index, item_value, input ready);
  modport sink   (input valid, mode, entry_index, item_value, output ready);
endinterface

interface tsos_result_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [tsos_pkg::COUNT_W-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

interface tsos_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tsos_pkg::COUNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[rtl/core/transpose_self_organizing_search_top.sv]
// Top level of the transpose self-organizing search block.
// Joins tsos_ctrl and tsos_datapath to the channel interfaces of tsos_if.
`default_nettype none

// A table of DEPTH signed 32-bit words, the first active_count of them in
// use. A load transaction (mode 0) writes one word and gives no result;
// loads beyond DEPTH are dropped. A search transaction (mode 1) scans
// from position 0 at one word per cycle through the single read port of
// the table RAM and returns found and the position of the first match, or
// min(active_count, DEPTH) on a miss; a match above position 0 is swapped
// with the word before it using two writes on the RAM write port. The
// result waits in the controller while the output register is full. The
// input is ready again in the cycle after the result is posted. The table
// has no reset: search only words that have been loaded. The configuration
// channel is always ready and should be written only while the block is
// idle.
module transpose_self_organizing_search_top #(
  parameter int DEPTH = tsos_pkg::DEPTH_DEFAULT
) (
  input wire logic      clk,
  input wire logic      rst,
  tsos_item_if.sink     item,
  tsos_result_if.source result,
  tsos_cfg_if.sink      cfg
);

  import tsos_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg.ready = 1'b1;

  tsos_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_mode  (item.mode),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  tsos_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg.valid && cfg.ready),
    .cfg_data    (cfg.data),
    .entry_index (item.entry_index),
    .item_value  (item.item_value),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .found       (result.found),
    .position    (result.position)
  );

  a_post_before_valid : assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(cmd.post))
    else $error("result valid rose without a post command");

  a_one_writer : assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_entry, cmd.swap_lo, cmd.swap_hi}))
    else $error("more than one table write source active");

  a_swap_order : assert property (@(posedge clk) disable iff (rst)
    cmd.swap_lo |=> cmd.swap_hi)
    else $error("swap second half did not follow first half");

  a_hit_miss_excl : assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> !(status.hit && status.miss))
    else $error("scan reports hit and miss together");

endmodule

`default_nettype wire

[rtl/core/tsos_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tsos_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/tsos_ctrl.sv]
// Controller state machine of the transpose self-organizing search block.
// Sequences load, scan, swap and result posting; uses tsos_pkg.
`default_nettype none

module tsos_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  input  wire logic              item_mode,
  output logic                   item_ready,
  input  wire tsos_pkg::status_t status,
  output tsos_pkg::cmd_t         cmd
);

  import tsos_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if (item_mode == MODE_SEARCH) begin
            cmd.start  = 1'b1;
            state_next = S_SCAN;
          end else begin
            cmd.load_entry = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.hit) begin
          state_next = status.hit_above_zero ? S_SWAP_LO : S_DONE;
        end else if (status.miss) begin
          state_next = S_DONE;
        end
      end
      S_SWAP_LO: begin
        cmd.swap_lo = 1'b1;
        state_next  = S_SWAP_HI;
      end
      S_SWAP_HI: begin
        cmd.swap_hi = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        // hold until the output register can take the result
        if (status.out_free) begin
          cmd.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/tsos_datapath.sv]
// Datapath of the transpose self-organizing search block: entry table RAM,
// scan counter, compare pipeline, swap writes and output register.
// Uses tsos_pkg and tsos_ram.
`default_nettype none

module tsos_datapath #(
  parameter int DEPTH = tsos_pkg::DEPTH_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire tsos_pkg::cmd_t                      cmd,
  output tsos_pkg::status_t                        status,
  input  wire logic                                cfg_we,
  input  wire logic [tsos_pkg::COUNT_W-1:0]        cfg_data,
  input  wire logic [tsos_pkg::IDX_W-1:0]          entry_index,
  input  wire logic signed [tsos_pkg::DATA_W-1:0]  item_value,
  output logic                                     res_valid,
  input  wire logic                                res_ready,
  output logic                                     found,
  output logic [tsos_pkg::COUNT_W-1:0]             position
);

  import tsos_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam logic [KW-1:0] DEPTH_K = KW'(DEPTH);

  logic [COUNT_W-1:0] active_count;
  logic [DATA_W-1:0]  key;
  logic [KW-1:0]      limit;
  logic [KW-1:0]      scan_idx;
  logic               pend_valid;
  logic [KW-1:0]      pend_pos;
  logic [DATA_W-1:0]  prev_data;
  logic               res_found;
  logic [KW-1:0]      res_pos;

  logic [KW-1:0]      count_k;
  logic [KW-1:0]      limit_next;
  logic [KW-1:0]      idx_k;
  logic [KW-1:0]      pos_dec;
  logic               load_ok;
  logic               more;
  logic               hit_now;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [DATA_W-1:0]  ram_wdata;
  logic [DATA_W-1:0]  ram_rdata;

  assign count_k    = KW'(active_count);
  assign limit_next = (count_k > DEPTH_K) ? DEPTH_K : count_k;
  assign idx_k      = KW'(entry_index);
  assign load_ok    = idx_k < DEPTH_K;
  assign pos_dec    = res_pos - KW'(1);
  assign more       = scan_idx < limit;
  // rdata belongs to pend_pos when pend_valid is set
  assign hit_now    = pend_valid && (ram_rdata == key);

  assign status.hit            = hit_now;
  assign status.hit_above_zero = pend_pos != '0;
  assign status.miss           = !pend_valid && !more;
  assign status.out_free       = !res_valid || res_ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_k[AW-1:0];
    ram_wdata = item_value;
    if (cmd.load_entry) begin
      ram_we = load_ok;
    end else if (cmd.swap_lo) begin
      ram_we    = 1'b1;
      ram_waddr = pos_dec[AW-1:0];
      ram_wdata = key;
    end else if (cmd.swap_hi) begin
      ram_we    = 1'b1;
      ram_waddr = res_pos[AW-1:0];
      ram_wdata = prev_data;
    end
  end

  tsos_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= '0;
    end else if (cfg_we) begin
      active_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.start) begin
      pend_valid <= 1'b0;
    end else if (cmd.scan && !hit_now) begin
      pend_valid <= more;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key      <= item_value;
      limit    <= limit_next;
      scan_idx <= '0;
    end else if (cmd.scan && !hit_now) begin
      if (more) begin
        scan_idx <= scan_idx + KW'(1);
        pend_pos <= scan_idx;
      end
      // keep the last compared entry: it is the neighbor of the next match
      if (pend_valid) begin
        prev_data <= ram_rdata;
      end
    end
    if (cmd.scan && hit_now) begin
      res_found <= 1'b1;
      res_pos   <= pend_pos;
    end else if (cmd.scan && status.miss) begin
      res_found <= 1'b0;
      res_pos   <= limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.post) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      found    <= res_found;
      position <= res_pos[COUNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Testbench for transpose_self_organizing_search_top: directed table, then random phases.
// Predicts search hits, miss positions and the transposition swaps on its own table copy.
// Depends on tsos_pkg, the tsos_if channel interfaces and the RTL top level.
`default_nettype none

module tb_top;
  import tsos_pkg::*;

  localparam int DEPTH          = DEPTH_DEFAULT;
  localparam int HALF_PERIOD    = 2;
  localparam int RESET_CYCLES   = 12;
  localparam int DRAIN_CYCLES   = DEPTH + 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF_LEN   = 500;
  localparam int PHASES         = 18;
  localparam int SEARCHES_PER_PHASE = 85;

  localparam logic [DATA_W-1:0] MAX_WORD = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] MIN_WORD = 32'h8000_0000;
  localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] HIGH_PAT = 32'h5A5A_5A5A;

  typedef struct packed {
    logic               found;
    logic [COUNT_W-1:0] position;
  } search_result_t;

  typedef enum logic [1:0] {ROW_COUNT, ROW_LOAD, ROW_SEARCH} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [IDX_W-1:0]   idx;
    logic [DATA_W-1:0]  value;
    logic               typed;
    logic               exp_found;
    logic [COUNT_W-1:0] exp_pos;
  } stim_row_t;

  stim_row_t directed_rows [21] = '{
    '{ROW_COUNT,  6'd0,  32'd0,    1'b0, 1'b0, 7'd0},
    '{ROW_SEARCH, 6'd0,  32'd0,    1'b1, 1'b0, 7'd0},  // empty table misses at 0
    '{ROW_LOAD,   6'd0,  MAX_WORD, 1'b0, 1'b0, 7'd0},
    '{ROW_LOAD,   6'd1,  MIN_WORD, 1'b0, 1'b0, 7'd0},
    '{ROW_LOAD,   6'd2,  32'd0,    1'b0, 1'b0, 7'd0},
    '{ROW_LOAD,   6'd3,  ALL_ONES, 1'b0, 1'b0, 7'd0},
    '{ROW_LOAD,   6'd63, HIGH_PAT, 1'b0, 1'b0, 7'd0},
    '{ROW_COUNT,  6'd0,  32'd4,    1'b0, 1'b0, 7'd0},
    '{ROW_SEARCH, 6'd63, MAX_WORD, 1'b1, 1'b1, 7'd0},  // match at zero, no swap
    '{ROW_SEARCH, 6'd21, MIN_WORD, 1'b1, 1'b1, 7'd1},
    '{ROW_SEARCH, 6'd42, MIN_WORD, 1'b0, 1'b0, 7'd0},
    '{ROW_SEARCH, 6'd0,  ALL_ONES, 1'b1, 1'b1, 7'd3},
    '{ROW_SEARCH, 6'd0,  ALL_ONES, 1'b0, 1'b0, 7'd0},
    '{ROW_SEARCH, 6'd0,  32'd12345, 1'b1, 1'b0, 7'd4},
    '{ROW_LOAD,   6'd3,  ALL_ONES, 1'b0, 1'b0, 7'd0},  // duplicate key further back
    '{ROW_SEARCH, 6'd0,  ALL_ONES, 1'b0, 1'b0, 7'd0},
    '{ROW_COUNT,  6'd0,  32'd1,    1'b0, 1'b0, 7'd0},
    '{ROW_SEARCH, 6'd0,  HIGH_PAT, 1'b1, 1'b0, 7'd1},  // word 63 lies beyond the count
    '{ROW_SEARCH, 6'd0,  ALL_ONES, 1'b1, 1'b1, 7'd0},
    '{ROW_COUNT,  6'd0,  32'd2,    1'b0, 1'b0, 7'd0},
    '{ROW_SEARCH, 6'd0,  MIN_WORD, 1'b0, 1'b0, 7'd0}
  };

  logic clk = 1'b0;
  logic rst;

  tsos_item_if   item_bus();
  tsos_result_if result_bus();
  tsos_cfg_if    cfg_bus();

  transpose_self_organizing_search_top #(.DEPTH(DEPTH)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Shadow copy of the table and the count register
  logic [DATA_W-1:0]  model_words [DEPTH];
  logic [DEPTH-1:0]   loaded_mask;
  logic [COUNT_W-1:0] model_count;

  search_result_t pending_results [$];
  int mismatches;
  int items_sent;
  int quiet_cycles;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_cycles;

  function automatic int active_span();
    return (model_count > DEPTH) ? DEPTH : int'(model_count);
  endfunction

  // Scan for the first match, then move it one place toward the front
  function automatic search_result_t search_and_transpose(input logic [DATA_W-1:0] key);
    search_result_t res;
    int span;
    int hit_at;
    logic [DATA_W-1:0] held;
    span = active_span();
    hit_at = -1;
    for (int i = 0; i < span; i++)
      if (hit_at < 0 && model_words[i] == key) hit_at = i;
    if (hit_at < 0) begin
      res.found = 1'b0;
      res.position = COUNT_W'(span);
    end else begin
      res.found = 1'b1;
      res.position = COUNT_W'(hit_at);
      if (hit_at > 0) begin
        held = model_words[hit_at];
        model_words[hit_at] = model_words[hit_at - 1];
        model_words[hit_at - 1] = held;
      end
    end
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value(input int style);
    logic [DATA_W-1:0] v;
    if (style == 0 || (style == 2 && $urandom_range(1) == 0)) begin
      v = $urandom;
    end else begin
      case ($urandom_range(5))
        0: v = MAX_WORD;
        1: v = MIN_WORD;
        2: v = '0;
        3: v = ALL_ONES;
        default: v = DATA_W'($urandom_range(1, 6));
      endcase
    end
    return v;
  endfunction

  task automatic push_item(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] val, input bit typed = 1'b0,
                           input search_result_t typed_res = '0);
    search_result_t res;
    int gap;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      item_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_bus.valid       <= 1'b1;
    item_bus.mode        <= op;
    item_bus.entry_index <= idx;
    item_bus.item_value  <= val;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    items_sent++;
    if (op == MODE_LOAD) begin
      model_words[idx] = val;
      loaded_mask[idx] = 1'b1;
    end else begin
      res = search_and_transpose(val);
      pending_results.push_back(typed ? typed_res : res);
    end
  endtask

  // Wait out every search in flight before touching the count register
  task automatic drain_block();
    @(negedge clk);
    item_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] count_val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= count_val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    model_count = count_val;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic run_phase(input int phase_no, input logic [COUNT_W-1:0] count_val);
    int span;
    int style;
    int sel;
    bit refresh;
    logic [DATA_W-1:0] hot_key;
    logic [DATA_W-1:0] key;
    if (items_sent < 580) begin
      send_idle_pct = 11;
      recv_idle_pct = 70;
    end else if (items_sent < 1160) begin
      send_idle_pct = 70;
      recv_idle_pct = 11;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    drain_block();
    write_count(count_val);
    span = active_span();
    style = $urandom_range(2);
    refresh = ($urandom_range(3) == 0);
    for (int i = 0; i < span; i++)
      if (refresh || !loaded_mask[i])
        push_item(MODE_LOAD, IDX_W'(i), pick_value(style));
    hot_key = (span > 0) ? model_words[span - 1] : pick_value(style);
    if (phase_no == 1) hold_off_cycles = HOLD_OFF_LEN;
    for (int n = 0; n < SEARCHES_PER_PHASE; n++) begin
      sel = $urandom_range(99);
      if (sel < 15) begin
        push_item(MODE_LOAD, IDX_W'($urandom_range(DEPTH - 1)), pick_value(style));
      end else begin
        if (span == 0 || sel >= 90)
          key = pick_value(style);
        else if (sel < 60)
          key = model_words[$urandom_range(span - 1)];
        else
          key = hot_key;
        push_item(MODE_SEARCH, IDX_W'($urandom_range(DEPTH - 1)), key);
      end
    end
  endtask

  initial begin
    int fixed_counts [10];
    logic [COUNT_W-1:0] count_val;
    search_result_t typed_res;
    fixed_counts = '{64, 127, 1, 0, 2, 17, 64, 65, 3, 40};
    rst = 1'b1;
    item_bus.valid = 1'b0;
    item_bus.mode = MODE_LOAD;
    item_bus.entry_index = '0;
    item_bus.item_value = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    loaded_mask = '0;
    model_count = '0;
    mismatches = 0;
    items_sent = 0;
    hold_off_cycles = 0;
    send_idle_pct = 11;
    recv_idle_pct = 70;
    for (int i = 0; i < DEPTH; i++) model_words[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      case (directed_rows[r].kind)
        ROW_COUNT: begin
          drain_block();
          write_count(directed_rows[r].value[COUNT_W-1:0]);
        end
        ROW_LOAD: begin
          push_item(MODE_LOAD, directed_rows[r].idx, directed_rows[r].value);
        end
        default: begin
          typed_res.found = directed_rows[r].exp_found;
          typed_res.position = directed_rows[r].exp_pos;
          push_item(MODE_SEARCH, directed_rows[r].idx, directed_rows[r].value,
                    directed_rows[r].typed, typed_res);
        end
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p < 10)
        count_val = COUNT_W'(fixed_counts[p]);
      else if ($urandom_range(7) == 0)
        count_val = COUNT_W'($urandom_range(65, 127));
      else
        count_val = COUNT_W'($urandom_range(DEPTH));
      run_phase(p, count_val);
    end

    drain_block();
    if (mismatches == 0 && pending_results.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles != 0) begin
        result_bus.ready <= 1'b0;
        repeat (hold_off_cycles - 1) @(negedge clk);
        hold_off_cycles = 0;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    search_result_t want;
    if (!rst) begin
      if (result_bus.valid && result_bus.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: expected none, actual found %0d position %0d",
                   $time, result_bus.found, result_bus.position);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (result_bus.found !== want.found) begin
            $display("%0t found mismatch: expected %0d actual %0d", $time,
                     want.found, result_bus.found);
            mismatches++;
          end
          if (result_bus.position !== want.position) begin
            $display("%0t position mismatch: expected %0d actual %0d", $time,
                     want.position, result_bus.position);
            mismatches++;
          end
        end
      end
      if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet_cycles <= 0;
      else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_top: FAIL");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end else begin
      quiet_cycles <= 0;
    end
  end

endmodule

`default_nettype wire
